>>> rtl/core/cpu_alu_with_flags_defines.svh
// assertion macros used by the alu top-level rtl file
`ifndef CPU_ALU_WITH_FLAGS_DEFINES_SVH
`define CPU_ALU_WITH_FLAGS_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication, checked on clk, off during reset
`define CALU_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication, checked on clk, off during reset
`define CALU_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define CALU_ASSERT_IMP(lbl, ante, cons, msg)
`define CALU_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

>>> rtl/core/calu_pkg.sv
// types and constants of the alu
`default_nettype none

package calu_pkg;

    typedef enum logic [3:0] {
        ACT_ADD   = 4'd0,
        ACT_ADC   = 4'd1,
        ACT_AND   = 4'd2,
        ACT_OR    = 4'd3,
        ACT_XOR   = 4'd4,
        ACT_CP    = 4'd5,
        ACT_INC8  = 4'd6,
        ACT_DEC8  = 4'd7,
        ACT_CPL   = 4'd8,
        ACT_CCF   = 4'd9,
        ACT_DAA   = 4'd10,
        ACT_ADD16 = 4'd11,
        ACT_ADDSP = 4'd12,
        ACT_INC16 = 4'd13,
        ACT_DEC16 = 4'd14
    } action_e;

    // flag bit positions
    localparam int unsigned FLAG_Z = 3;
    localparam int unsigned FLAG_N = 2;
    localparam int unsigned FLAG_H = 1;
    localparam int unsigned FLAG_C = 0;

    localparam logic [7:0] DAA_LO_ADJ   = 8'h06;
    localparam logic [7:0] DAA_HI_ADJ   = 8'h60;
    localparam logic [7:0] DAA_HI_LIMIT = 8'h99;
    localparam logic [3:0] DAA_LO_LIMIT = 4'h9;

    typedef struct packed {
        logic [3:0]  action;
        logic [7:0]  acc_value;
        logic [7:0]  byte_operand;
        logic [15:0] wide_value;
        logic [15:0] wide_operand;
        logic [3:0]  flags_in;
    } req_t;

    typedef struct packed {
        logic [7:0]  byte_result;
        logic [15:0] wide_result;
        logic [3:0]  flags_out;
        logic        write_back;
    } rsp_t;

endpackage

`default_nettype wire

>>> rtl/core/calu_if.sv
// request and response channel interfaces of the alu
`default_nettype none

interface calu_req_if;
    logic        valid;
    logic        ready;
    logic [3:0]  action;
    logic [7:0]  acc_value;
    logic [7:0]  byte_operand;
    logic [15:0] wide_value;
    logic [15:0] wide_operand;
    logic [3:0]  flags_in;

    modport source (
        output valid, action, acc_value, byte_operand, wide_value, wide_operand, flags_in,
        input  ready
    );
    modport sink (
        input  valid, action, acc_value, byte_operand, wide_value, wide_operand, flags_in,
        output ready
    );
endinterface

interface calu_rsp_if;
    logic        valid;
    logic        ready;
    logic [7:0]  byte_result;
    logic [15:0] wide_result;
    logic [3:0]  flags_out;
    logic        write_back;

    modport source (
        output valid, byte_result, wide_result, flags_out, write_back,
        input  ready
    );
    modport sink (
        input  valid, byte_result, wide_result, flags_out, write_back,
        output ready
    );
endinterface

`default_nettype wire

>>> rtl/core/calu_stage.sv
// pipeline register stage with valid/ready flow control
`default_nettype none

module calu_stage #(
    parameter type data_t = logic
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  in_valid,
    output logic       in_ready,
    input  wire data_t in_data,
    output logic       out_valid,
    input  wire logic  out_ready,
    output data_t      out_data
);

    logic  valid_reg;
    logic  valid_next;
    data_t data_reg;

    // take a new transaction when empty or when the held one leaves this cycle
    assign in_ready   = !valid_reg || out_ready;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= in_data;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

`default_nettype wire

>>> rtl/core/calu_datapath.sv
// combinational alu: result, flags and write-back mark for one request
`default_nettype none

module calu_datapath (
    input  wire calu_pkg::req_t req,
    output calu_pkg::rsp_t      rsp
);

    logic [7:0]  a;
    logic [7:0]  b;
    logic [15:0] w;
    logic [15:0] wo;
    logic [3:0]  fin;
    logic        cin;
    logic        adc_c;
    logic [8:0]  sum9;
    logic [4:0]  half5;
    logic [16:0] sum17;
    logic [12:0] half13;
    logic [15:0] sp_ext;
    logic [4:0]  sp_half;
    logic [8:0]  sp_low;
    logic [7:0]  daa_adj;
    logic        daa_carry;
    logic [7:0]  daa_res;
    logic [7:0]  r8;
    logic [15:0] r16;

    always_comb
    begin
        a      = req.acc_value;
        b      = req.byte_operand;
        w      = req.wide_value;
        wo     = req.wide_operand;
        fin    = req.flags_in;
        cin    = fin[calu_pkg::FLAG_C];
        adc_c  = (req.action == calu_pkg::ACT_ADC) ? cin : 1'b0;
        sum9   = {1'b0, a} + {1'b0, b} + {8'b0, adc_c};
        half5  = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'b0, adc_c};
        sum17  = {1'b0, w} + {1'b0, wo};
        half13 = {1'b0, w[11:0]} + {1'b0, wo[11:0]};
        sp_ext  = {{8{b[7]}}, b};
        sp_half = {1'b0, w[3:0]} + {1'b0, b[3:0]};
        sp_low  = {1'b0, w[7:0]} + {1'b0, b};

        // decimal adjust after add or subtract
        daa_adj   = 8'h00;
        daa_carry = cin;
        if (fin[calu_pkg::FLAG_N])
        begin
            if (fin[calu_pkg::FLAG_H])
            begin
                daa_adj = daa_adj | calu_pkg::DAA_LO_ADJ;
            end
            if (cin)
            begin
                daa_adj = daa_adj | calu_pkg::DAA_HI_ADJ;
            end
            daa_res = a - daa_adj;
        end
        else
        begin
            if (fin[calu_pkg::FLAG_H] || (a[3:0] > calu_pkg::DAA_LO_LIMIT))
            begin
                daa_adj = daa_adj | calu_pkg::DAA_LO_ADJ;
            end
            if (cin || (a > calu_pkg::DAA_HI_LIMIT))
            begin
                daa_adj   = daa_adj | calu_pkg::DAA_HI_ADJ;
                daa_carry = 1'b1;
            end
            daa_res = a + daa_adj;
        end

        r8  = 8'h00;
        r16 = 16'h0000;
        rsp.flags_out  = fin;
        rsp.write_back = 1'b1;

        unique case (req.action) inside
            calu_pkg::ACT_ADD, calu_pkg::ACT_ADC:
            begin
                r8 = sum9[7:0];
                rsp.flags_out = {(sum9[7:0] == 8'h00), 1'b0, half5[4], sum9[8]};
            end
            calu_pkg::ACT_AND:
            begin
                r8 = a & b;
                rsp.flags_out = {((a & b) == 8'h00), 1'b0, 1'b1, 1'b0};
            end
            calu_pkg::ACT_OR:
            begin
                r8 = a | b;
                rsp.flags_out = {((a | b) == 8'h00), 3'b000};
            end
            calu_pkg::ACT_XOR:
            begin
                r8 = a ^ b;
                rsp.flags_out = {((a ^ b) == 8'h00), 3'b000};
            end
            calu_pkg::ACT_CP:
            begin
                r8 = a - b;
                rsp.flags_out = {(a == b), 1'b1, (a[3:0] < b[3:0]), (a < b)};
                rsp.write_back = 1'b0;
            end
            calu_pkg::ACT_INC8:
            begin
                r8 = a + 8'd1;
                rsp.flags_out = {(a == 8'hFF), 1'b0, (a[3:0] == 4'hF), cin};
            end
            calu_pkg::ACT_DEC8:
            begin
                r8 = a - 8'd1;
                rsp.flags_out = {(a == 8'h01), 1'b1, (a[3:0] == 4'h0), cin};
            end
            calu_pkg::ACT_CPL:
            begin
                r8 = ~a;
                rsp.flags_out = {fin[calu_pkg::FLAG_Z], 1'b1, 1'b1, cin};
            end
            calu_pkg::ACT_CCF:
            begin
                rsp.flags_out = {fin[calu_pkg::FLAG_Z], 1'b0, 1'b0, !cin};
                rsp.write_back = 1'b0;
            end
            calu_pkg::ACT_DAA:
            begin
                r8 = daa_res;
                rsp.flags_out = {(daa_res == 8'h00), fin[calu_pkg::FLAG_N], 1'b0, daa_carry};
            end
            calu_pkg::ACT_ADD16:
            begin
                r16 = sum17[15:0];
                rsp.flags_out = {fin[calu_pkg::FLAG_Z], 1'b0, half13[12], sum17[16]};
            end
            calu_pkg::ACT_ADDSP:
            begin
                r16 = w + sp_ext;
                rsp.flags_out = {1'b0, 1'b0, sp_half[4], sp_low[8]};
            end
            calu_pkg::ACT_INC16:
            begin
                r16 = w + 16'd1;
            end
            calu_pkg::ACT_DEC16:
            begin
                r16 = w - 16'd1;
            end
            default:
            begin
                // unused code: nothing written, flags pass through
                rsp.write_back = 1'b0;
            end
        endcase

        rsp.byte_result = r8;
        rsp.wide_result = r16;
    end

endmodule

`default_nettype wire

>>> rtl/core/cpu_alu_with_flags.sv
// top level of the alu: input register, datapath, result register
// path: a request taken into the input register has its result held in the result register, then leaves as a response
// throughput: one transaction per cycle, any stall on the response side
//   backs up through the result and input registers
// reset: rst_n clears both stage valid bits asynchronously; payload is not reset
`default_nettype none

`include "cpu_alu_with_flags_defines.svh"

module cpu_alu_with_flags (
    input  wire logic clk,
    input  wire logic rst_n,
    calu_req_if.sink   req,
    calu_rsp_if.source rsp
);

    calu_pkg::req_t req_data;
    calu_pkg::req_t s1_data;
    calu_pkg::rsp_t s1_result;
    calu_pkg::rsp_t s2_data;
    logic           s1_valid;
    logic           s1_ready;

    assign req_data = '{
        action:       req.action,
        acc_value:    req.acc_value,
        byte_operand: req.byte_operand,
        wide_value:   req.wide_value,
        wide_operand: req.wide_operand,
        flags_in:     req.flags_in
    };

    calu_stage #(
        .data_t (calu_pkg::req_t)
    ) u_in_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .in_data   (req_data),
        .out_valid (s1_valid),
        .out_ready (s1_ready),
        .out_data  (s1_data)
    );

    calu_datapath u_datapath (
        .req (s1_data),
        .rsp (s1_result)
    );

    calu_stage #(
        .data_t (calu_pkg::rsp_t)
    ) u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s1_valid),
        .in_ready  (s1_ready),
        .in_data   (s1_result),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .out_data  (s2_data)
    );

    assign rsp.byte_result = s2_data.byte_result;
    assign rsp.wide_result = s2_data.wide_result;
    assign rsp.flags_out   = s2_data.flags_out;
    assign rsp.write_back  = s2_data.write_back;

    // both stages full and the consumer stalled: no new request may enter
    `CALU_ASSERT_IMP(a_no_overrun, s1_valid && rsp.valid && !rsp.ready, !req.ready, "request accepted while both stages full")
    // a stalled input stage keeps its transaction
    `CALU_ASSERT_NXT(a_s1_hold, s1_valid && !s1_ready, s1_valid, "input stage dropped a stalled transaction")
    // compare never writes back
    `CALU_ASSERT_IMP(a_cp_no_wb, s1_valid && (s1_data.action == calu_pkg::ACT_CP), !s1_result.write_back, "compare marked for write-back")
    // 16-bit increment and decrement leave all flags alone
    `CALU_ASSERT_IMP(a_incdec16_flags, s1_valid && ((s1_data.action == calu_pkg::ACT_INC16) || (s1_data.action == calu_pkg::ACT_DEC16)), s1_result.flags_out == s1_data.flags_in, "16-bit inc/dec changed flags")
    // at most one of the two result fields is ever nonzero
    `CALU_ASSERT_IMP(a_one_width, rsp.valid, (rsp.byte_result == 8'h00) || (rsp.wide_result == 16'h0000), "byte and wide results both nonzero")

endmodule

`default_nettype wire
